[rtl/utf8_to_wide_decoder_top_defines.svh]
// assertion macros for the utf8 to wide decoder
// used by utf8_to_wide_decoder_top; needs clk and arst_n in the including scope
`ifndef UTF8_TO_WIDE_DECODER_TOP_DEFINES_SVH
`define UTF8_TO_WIDE_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked on rising clk outside reset
`define UTWD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on rising clk outside reset
`define UTWD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/utwd_pkg.sv]
// shared types and constants for the utf8 to wide decoder
// no dependencies; used by utwd_decode, utf8_to_wide_decoder_top, utwd_checker and tb
package utwd_pkg;

	localparam int BYTE_W     = 8;
	localparam int CU_W       = 21;
	localparam int MAX_UNITS  = 4;
	localparam int HELD_DEPTH = 3;

	localparam logic [CU_W-1:0] PLANE1_BASE = 21'h010000;
	localparam logic [CU_W-1:0] SURR_HI     = 21'h00D800;
	localparam logic [CU_W-1:0] SURR_LO     = 21'h00DC00;

	typedef logic [CU_W-1:0] unit_t;
	typedef logic [BYTE_W-1:0] byte_t;

	// pending sequence state
	typedef struct packed {
		logic [1:0] count;
		logic [2:0] len;
		unit_t      accum;
	} dec_state_t;

	// decode result for one input byte
	typedef struct packed {
		logic [MAX_UNITS-1:0][CU_W-1:0] units;
		logic [2:0]                     n_units;
		dec_state_t                     nxt;
		logic [HELD_DEPTH-1:0]          hb_we;
	} dec_out_t;

endpackage

[rtl/utwd_decode.sv]
// combinational decode of one utf8 byte against the pending sequence state
// depends on utwd_pkg
module utwd_decode (
	input  utwd_pkg::dec_state_t                                cur,
	input  logic [utwd_pkg::HELD_DEPTH-1:0][utwd_pkg::BYTE_W-1:0] held,
	input  utwd_pkg::byte_t                                     in_byte,
	input  logic                                                in_last,
	input  logic                                                utf16_mode,
	output utwd_pkg::dec_out_t                                  res
);

	logic            is_cont;
	logic            lead2, lead3, lead4, fresh_buf;
	logic [2:0]      fresh_len;
	utwd_pkg::unit_t fresh_bits;
	utwd_pkg::unit_t acc, v;
	utwd_pkg::unit_t raw_in;

	assign is_cont   = (in_byte[7:6] == 2'b10);
	assign lead2     = (in_byte[7:5] == 3'b110);
	assign lead3     = (in_byte[7:4] == 4'b1110);
	assign lead4     = (in_byte[7:3] == 5'b11110);
	assign fresh_buf = lead2 | lead3 | lead4;
	assign raw_in    = {13'd0, in_byte};
	assign acc       = {cur.accum[14:0], in_byte[5:0]};
	assign v         = acc - utwd_pkg::PLANE1_BASE;

	always_comb begin
		fresh_len  = 3'd4;
		fresh_bits = {18'd0, in_byte[2:0]};
		if (lead2) begin
			fresh_len  = 3'd2;
			fresh_bits = {16'd0, in_byte[4:0]};
		end else if (lead3) begin
			fresh_len  = 3'd3;
			fresh_bits = {17'd0, in_byte[3:0]};
		end
	end

	always_comb begin
		logic [2:0] n;
		logic       do_fresh;
		res      = '0;
		res.nxt  = cur;
		n        = 3'd0;
		do_fresh = 1'b0;
		if (cur.count == 2'd0) begin
			do_fresh = 1'b1;
		end else if (is_cont) begin
			if (({1'b0, cur.count} + 3'd1) >= cur.len) begin
				// sequence complete
				res.nxt = '0;
				if (utf16_mode && (acc[20:16] != 5'd0)) begin
					res.units[n[1:0]] = utwd_pkg::SURR_HI + {10'd0, v[20:10]};
					n = n + 3'd1;
					res.units[n[1:0]] = utwd_pkg::SURR_LO + {11'd0, v[9:0]};
					n = n + 3'd1;
				end else begin
					res.units[n[1:0]] = acc;
					n = n + 3'd1;
				end
			end else begin
				res.hb_we[cur.count] = 1'b1;
				res.nxt.count        = cur.count + 2'd1;
				res.nxt.accum        = acc;
				if (in_last) begin
					// end of string: flush held bytes plus this one
					for (int k = 0; k < utwd_pkg::HELD_DEPTH; k++) begin
						if (2'(k) < cur.count) begin
							res.units[n[1:0]] = {13'd0, held[k]};
							n = n + 3'd1;
						end
					end
					res.units[n[1:0]] = raw_in;
					n = n + 3'd1;
					res.nxt = '0;
				end
			end
		end else begin
			// broken sequence: held bytes go out raw, then restart
			for (int k = 0; k < utwd_pkg::HELD_DEPTH; k++) begin
				if (2'(k) < cur.count) begin
					res.units[n[1:0]] = {13'd0, held[k]};
					n = n + 3'd1;
				end
			end
			res.nxt  = '0;
			do_fresh = 1'b1;
		end

		if (do_fresh) begin
			if (fresh_buf) begin
				res.hb_we[0]  = 1'b1;
				res.nxt.count = 2'd1;
				res.nxt.len   = fresh_len;
				res.nxt.accum = fresh_bits;
				if (in_last) begin
					res.units[n[1:0]] = raw_in;
					n = n + 3'd1;
					res.nxt = '0;
				end
			end else begin
				// ascii, stray continuation or invalid lead
				res.units[n[1:0]] = raw_in;
				n = n + 3'd1;
			end
		end
		res.n_units = n;
	end

endmodule

[rtl/utf8_to_wide_decoder_top.sv]
// top level of the utf8 to wide decoder: input register, decode, output buffer
// depends on utwd_pkg, utwd_decode and utf8_to_wide_decoder_top_defines.svh
//
// Takes one utf8 byte per input beat (tlast marks the end of the string) and
// gives utf32 code points, or utf16 code units when utf16_mode is set, one per
// output beat; tlast on the output marks the last code unit caused by an input
// byte. Bad leads, broken sequences and bytes pending at the end of the string
// come out as their raw byte values. An accepted input beat passes the input
// register and then the output buffer. Bytes that give one or no code unit run
// at one beat per cycle while m_axis_tready is high; a byte that gives more
// code units (up to four) holds the output buffer until its last unit is sent,
// since that buffer sends one code unit per cycle while m_axis_tready is high,
// and the input stalls meanwhile. utf16_mode is written through the always ready
// cfg port; the user must do so only while the block is idle, it is not enforced.
`include "utf8_to_wide_decoder_top_defines.svh"

module utf8_to_wide_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,      // utf16_mode
	// byte input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	input  logic        s_axis_tlast,  // in_last
	// code unit output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [20:0] code_unit, [23:21] zero
	output logic        m_axis_tlast   // run_end
);

	// configuration register
	logic mode_q;

	// input register stage
	logic            v_s1;
	utwd_pkg::byte_t byte_s1;
	logic            last_s1;

	// pending sequence state; held bytes carry no reset, entries are written before read
	utwd_pkg::dec_state_t state_q;
	logic [utwd_pkg::HELD_DEPTH-1:0][utwd_pkg::BYTE_W-1:0] held_q;

	// output buffer for up to four code units of one byte
	logic [utwd_pkg::MAX_UNITS-1:0][utwd_pkg::CU_W-1:0] units_q;
	logic [2:0] cnt_q;
	logic [1:0] idx_q;
	logic       obuf_valid_q;

	utwd_pkg::dec_out_t dec;
	logic [1:0]         last_idx;
	logic               drain_last, buf_free, take_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	utwd_decode u_decode (
		.cur        (state_q),
		.held       (held_q),
		.in_byte    (byte_s1),
		.in_last    (last_s1),
		.utf16_mode (mode_q),
		.res        (dec)
	);

	// the stage moves on when the buffer is empty or sends its final unit now
	assign last_idx      = 2'(cnt_q - 3'd1);
	assign drain_last    = obuf_valid_q && m_axis_tready && (idx_q == last_idx);
	assign buf_free      = !obuf_valid_q || drain_last;
	assign take_s1       = v_s1 && buf_free;
	assign s_axis_tready = !v_s1 || take_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// sequence state advances once per decoded byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (take_s1) begin
			state_q <= dec.nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			for (int k = 0; k < utwd_pkg::HELD_DEPTH; k++) begin
				if (dec.hb_we[k]) begin
					held_q[k] <= byte_s1;
				end
			end
		end
	end

	// output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obuf_valid_q <= 1'b0;
			cnt_q        <= 3'd0;
			idx_q        <= 2'd0;
		end else if (take_s1 && (dec.n_units != 3'd0)) begin
			obuf_valid_q <= 1'b1;
			cnt_q        <= dec.n_units;
			idx_q        <= 2'd0;
		end else if (obuf_valid_q && m_axis_tready) begin
			if (drain_last) begin
				obuf_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && (dec.n_units != 3'd0)) begin
			units_q <= dec.units;
		end
	end

	assign m_axis_tvalid = obuf_valid_q;
	assign m_axis_tdata  = {3'd0, units_q[idx_q]};
	assign m_axis_tlast  = (idx_q == last_idx);

	// buffer count stays within one to four and the index inside it
	`UTWD_ASSERT_NOW(a_obuf_count, obuf_valid_q,
		(cnt_q != 3'd0) && (cnt_q <= 3'd4) && ({1'b0, idx_q} < cnt_q),
		"output buffer count or index out of range")
	// a pending sequence always has more bytes to come than it holds
	`UTWD_ASSERT_NOW(a_pending_len, state_q.count != 2'd0,
		state_q.len > {1'b0, state_q.count}, "pending count not below sequence length")
	// a decoded byte with results starts the buffer at its first unit
	`UTWD_ASSERT_NEXT(a_obuf_load, take_s1 && (dec.n_units != 3'd0),
		obuf_valid_q && (idx_q == 2'd0), "output buffer not loaded after decode")
	// a held stage behind a stalled, unfinished buffer blocks the input
	`UTWD_ASSERT_NOW(a_input_stall, v_s1 && obuf_valid_q && !m_axis_tready,
		!s_axis_tready, "input accepted while output buffer is stalled")

endmodule

[tb/utwd_checker.sv]
`timescale 1ns / 1ps
// checker for the utf8 to wide decoder: watches the cfg, byte and code unit channels,
// predicts the code units of every accepted byte and compares them beat by beat
// depends on utwd_pkg
module utwd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          fails,
	output int          pending
);

	typedef struct packed {
		utwd_pkg::unit_t code_unit;
		logic            run_end;
	} unit_beat_t;

	unit_beat_t      want_q[$];
	utwd_pkg::unit_t burst[$];
	unit_beat_t      head;
	int              fail_n;

	// decoder state as seen from outside
	utwd_pkg::byte_t held_q [utwd_pkg::HELD_DEPTH];
	int              held_n;
	int              seq_len;
	utwd_pkg::unit_t accum;
	logic            utf16_on;

	// one more predicted code unit for the current byte
	task automatic add_unit(utwd_pkg::unit_t u);
		burst = {burst, u};
	endtask

	task automatic put_point(utwd_pkg::unit_t cp);
		utwd_pkg::unit_t v;
		if (utf16_on && cp > 21'h00FFFF) begin
			v = cp - utwd_pkg::PLANE1_BASE;
			add_unit(utwd_pkg::SURR_HI + (v >> 10));
			add_unit(utwd_pkg::SURR_LO + (v & 21'h0003FF));
		end else begin
			add_unit(cp);
		end
	endtask

	task automatic flush_held();
		for (int k = 0; k < held_n; k++)
			add_unit(utwd_pkg::unit_t'(held_q[k]));
		held_n  = 0;
		seq_len = 0;
		accum   = '0;
	endtask

	// ascii, stray continuations and bad leads go straight out, good leads open a sequence
	task automatic open_seq(utwd_pkg::byte_t b);
		int len;
		len = 0;
		if (b[7:5] == 3'b110)
			len = 2;
		else if (b[7:4] == 4'b1110)
			len = 3;
		else if (b[7:3] == 5'b11110)
			len = 4;
		if (len == 0) begin
			add_unit(utwd_pkg::unit_t'(b));
		end else begin
			held_q[0] = b;
			held_n    = 1;
			seq_len   = len;
			accum     = utwd_pkg::unit_t'(b & (8'h7F >> len));
		end
	endtask

	task automatic decode_byte(utwd_pkg::byte_t b, logic last);
		unit_beat_t ub;
		burst = {};
		if (held_n == 0) begin
			open_seq(b);
		end else if (b[7:6] == 2'b10) begin
			accum = {accum[utwd_pkg::CU_W-7:0], b[5:0]};
			if (held_n + 1 >= seq_len) begin
				put_point(accum);
				held_n  = 0;
				seq_len = 0;
				accum   = '0;
			end else begin
				held_q[held_n] = b;
				held_n++;
			end
		end else begin
			flush_held();
			open_seq(b);
		end
		if (last && held_n != 0)
			flush_held();
		foreach (burst[i]) begin
			ub.code_unit = burst[i];
			ub.run_end   = (i == burst.size() - 1);
			want_q = {want_q, ub};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf16_on = 1'b0;
			held_q   = '{default: '0};
			held_n   = 0;
			seq_len  = 0;
			accum    = '0;
			want_q   = {};
			fail_n   = 0;
			fails   <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				utf16_on = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				decode_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (want_q.size() == 0) begin
					$error("unexpected code unit beat: code_unit 0x%06h run_end %0b",
						m_axis_tdata[20:0], m_axis_tlast);
					fail_n++;
				end else begin
					head = want_q.pop_front();
					if (m_axis_tdata[20:0] !== head.code_unit) begin
						$error("code_unit: expected 0x%06h, got 0x%06h",
							head.code_unit, m_axis_tdata[20:0]);
						fail_n++;
					end
					if (m_axis_tlast !== head.run_end) begin
						$error("run_end: expected %0b, got %0b", head.run_end, m_axis_tlast);
						fail_n++;
					end
				end
			end
			fails   <= fail_n;
			pending <= want_q.size();
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// testbench top for utf8_to_wide_decoder_top: clock, reset, byte stimulus, receiver
// stalls and the verdict; checking is left to utwd_checker (needs utwd_pkg)
module tb;

	// watchdog limit, far beyond the length of a correct run
	localparam int unsigned LIMIT = 200000;
	// idle cycles after the last expected beat: input register plus decode stage
	localparam int SETTLE = 4;
	// long receiver hold-off so the output buffer and input register fill up
	localparam int HOLD_CYCLES = 80;

	// directed bytes, {in_last, in_byte}
	localparam logic [8:0] DIRECTED [26] = '{
		9'h000, 9'h17F,                  // ascii extremes, end of string with nothing held
		9'h0C2, 9'h0A9,                  // two-byte sequence
		9'h0E2, 9'h082, 9'h0AC,          // three-byte sequence
		9'h0F0, 9'h09F, 9'h098, 9'h080,  // four-byte, surrogate pair in utf16 mode
		9'h080,                          // stray continuation byte with nothing held
		9'h0FF,                          // invalid lead 11111xxx
		9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,  // largest 21-bit value
		9'h0C2, 9'h041,                  // broken sequence, one byte held
		9'h0F0, 9'h090, 9'h080, 9'h0FF,  // broken after three held, four raw units
		9'h1C3,                          // lead at end of string is flushed raw
		9'h0F4, 9'h18F                   // string ends inside a sequence
	};

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic        cfg_data      = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;

	int          fails;
	int          pending;
	int          sent;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int          hold_req    = 0;
	int          hold_ack    = 0;
	int          hold_left   = 0;
	int unsigned cycle_n     = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	utf8_to_wide_decoder_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	utwd_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.fails         (fails),
		.pending       (pending)
	);

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
		if (cycle_n == LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// one byte beat; valid stays high into the next beat unless the sender idles
	task automatic send_byte(utwd_pkg::byte_t b, logic last);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent++;
	endtask

	// stop offering and wait until every predicted code unit has come out;
	// the first edge lets the checker count the byte accepted last
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// utf16_mode only changes with the decoder idle
	task automatic write_mode(logic mode);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic utwd_pkg::byte_t lead_byte(int len);
		utwd_pkg::byte_t r;
		r = utwd_pkg::byte_t'($urandom);
		case (len)
			2:       lead_byte = 8'hC0 | (r & 8'h1F);
			3:       lead_byte = 8'hE0 | (r & 8'h0F);
			default: lead_byte = 8'hF0 | (r & 8'h07);
		endcase
	endfunction

	function automatic utwd_pkg::byte_t cont_byte();
		cont_byte = 8'h80 | (utwd_pkg::byte_t'($urandom) & 8'h3F);
	endfunction

	// mostly well-formed characters with random payload, the rest truncated
	// sequences, stray continuations, invalid leads and plain noise
	task automatic send_string(int n_chars, bit end_mark);
		utwd_pkg::byte_t txt[$];
		int              kind;
		int              len;
		for (int c = 0; c < n_chars; c++) begin
			kind = $urandom_range(99);
			if (kind < 30) begin
				txt = {txt, utwd_pkg::byte_t'($urandom_range(127))};
			end else if (kind < 75) begin
				len = (kind < 45) ? 2 : (kind < 58) ? 3 : 4;
				txt = {txt, lead_byte(len)};
				repeat (len - 1) txt = {txt, cont_byte()};
			end else if (kind < 85) begin
				len = $urandom_range(2, 4);
				txt = {txt, lead_byte(len)};
				repeat ($urandom_range(0, len - 2)) txt = {txt, cont_byte()};
			end else if (kind < 90) begin
				txt = {txt, cont_byte()};
			end else if (kind < 95) begin
				txt = {txt, 8'hF8 | utwd_pkg::byte_t'($urandom_range(7))};
			end else begin
				txt = {txt, utwd_pkg::byte_t'($urandom_range(255))};
			end
		end
		foreach (txt[i])
			send_byte(txt[i], end_mark && i == txt.size() - 1);
	endtask

	task automatic run_random(int n_bytes);
		int stop;
		stop = sent + n_bytes;
		while (sent < stop)
			send_string($urandom_range(1, 6), $urandom_range(3) != 0);
	endtask

	initial begin
		sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed bytes in utf16 mode, no idling
		write_mode(1'b1);
		foreach (DIRECTED[i])
			send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

		// utf32 mode, sender idles a little, receiver a lot
		write_mode(1'b0);
		tx_idle_pct = 28;
		rx_idle_pct = 79;
		run_random(40);

		// utf16 mode, roles swapped; halfway the sender waits for the output to drain
		write_mode(1'b1);
		tx_idle_pct = 79;
		rx_idle_pct = 28;
		run_random(20);
		wait_drained();
		run_random(20);

		// utf32 mode at full rate; the receiver holds off while bytes keep coming
		write_mode(1'b0);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req++;
		run_random(40);

		wait_drained();
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/utwd_pkg.sv
rtl/utwd_decode.sv
rtl/utf8_to_wide_decoder_top.sv
tb/utwd_checker.sv
tb/tb.sv
